FILE: rtl/cdb_pkg.sv
// shared types and constants of the circular deque buffer
package cdb_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_TAIL = 2'd0,
        KIND_PUSH_HEAD = 2'd1,
        KIND_POP       = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell, already qualified
    typedef struct packed {
        logic push_tail;
        logic push_head;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: rtl/cdb_cell.sv
// one storage cell of the deque row
module cdb_cell
    import cdb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_word
);

    localparam logic [CNT_W-1:0] L_IDX = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_head) begin
            r_word <= i_left;
        end else if (i_ctl.pop) begin
            r_word <= i_right;
        end else if (i_ctl.push_tail && (i_count == L_IDX)) begin
            r_word <= i_data_in;
        end
    end

    assign o_word = r_word;

endmodule

FILE: rtl/circular_deque_buffer.sv
// top level of the circular deque buffer: cell row, count and result registers
//
//  channel   direction  handshake                 payload
//  command   in         start & !busy             i_kind, i_data_in
//  result    out        o_done (one-cycle strobe) o_data_out, o_status, o_count, o_is_empty
//
//  one transaction per clock: busy stays low and a command taken at one edge
//  gives its result on the ports during the following cycle
//  the figure is set by the cell row, which shifts or loads once per command
//  i_rst_n (synchronous, active low) empties the queue; cell contents are kept
//  the receiver cannot stall; o_done is a one-cycle strobe, payload holds to next command
module circular_deque_buffer
    import cdb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_data_out,
    output logic [1:0]            o_status,
    output logic [CNT_W-1:0]      o_count,
    output logic                  o_is_empty
);

    localparam logic [CNT_W-1:0] L_FULL = CNT_W'(DEPTH);

    // the head of the queue always sits in cell 0, the tail in cell count-1
    logic [DATA_WIDTH-1:0] w_word [DEPTH];

    t_cell_ctl             w_ctl;
    t_status               w_status;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;

    logic                  r_done,     n_done;
    logic [DATA_WIDTH-1:0] r_data_out, n_data_out;
    t_status               r_status,   n_status;
    logic [CNT_W-1:0]      r_count,    n_count;

    assign busy     = 1'b0;
    assign w_accept = start;
    assign w_full   = (r_count == L_FULL);
    assign w_empty  = (r_count == '0);

    // decode the command, refuse pushes while full and pops while empty
    always_comb begin
        w_ctl    = '0;
        w_status = ST_DONE;
        case (t_kind'(i_kind))
            KIND_PUSH_TAIL: begin
                if (w_full) w_status = ST_FULL;
                else        w_ctl.push_tail = w_accept;
            end
            KIND_PUSH_HEAD: begin
                if (w_full) w_status = ST_FULL;
                else        w_ctl.push_head = w_accept;
            end
            KIND_POP: begin
                if (w_empty) w_status = ST_EMPTY;
                else         w_ctl.pop = w_accept;
            end
            default: begin
                // unused code: no operation, reported as done
                w_status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_done     = w_accept;
        n_data_out = r_data_out;
        n_status   = r_status;
        n_count    = r_count;
        if (w_accept) begin
            n_status   = w_status;
            n_data_out = w_ctl.pop ? w_word[0] : '0;
            if (w_ctl.push_tail || w_ctl.push_head) begin
                n_count = r_count + 1'b1;
            end else if (w_ctl.pop) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    // cell row: a head push shifts toward the tail, a pop shifts toward the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_data_in;
        end else begin : g_mid_left
            assign w_left = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_right
            assign w_right = w_word[g+1];
        end

        cdb_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_data_in (i_data_in),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_word    (w_word[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_data_out <= n_data_out;
        r_status   <= n_status;
    end

    assign o_done     = r_done;
    assign o_data_out = r_data_out;
    assign o_status   = r_status;
    assign o_count    = r_count;
    assign o_is_empty = (r_count == '0);

endmodule
